// ===== rtl/rigid_body_step_aabb_resolve_defines.svh =====
// assertion macros used by the rtl checker file
`ifndef RIGID_BODY_STEP_AABB_RESOLVE_DEFINES_SVH
`define RIGID_BODY_STEP_AABB_RESOLVE_DEFINES_SVH

// antecedent implies consequent in the same cycle, outside reset
`define RBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs check failed");

// antecedent implies consequent in the next cycle, outside reset
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbs check failed");

// checked at every edge, reset included
`define RBS_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("rbs check failed");

`endif

// ===== rtl/rbs_pkg.sv =====
// types, codes and helpers of the rigid body stepper
`default_nettype none
package rbs_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic [7:0] idx_t;

  localparam logic [16:0] ONE_Q = 17'd65536;
  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  localparam int unsigned F_VALID = 0;
  localparam int unsigned F_MOVES = 1;
  localparam int unsigned F_GRAV  = 2;
  localparam int unsigned F_CHECK = 3;
  localparam int unsigned F_COLL  = 4;

  typedef enum logic [1:0] {
    OP_SHAPE  = 2'd0,
    OP_MOTION = 2'd1,
    OP_STEP   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_GRAVITY  = 3'd0,
    REG_DRAG     = 3'd1,
    REG_MAX_FALL = 3'd2,
    REG_MIN_DT   = 3'd3,
    REG_MAX_DT   = 3'd4
  } reg_e;

  // physics micro-steps: each issues one product and/or applies the previous one
  typedef enum logic [3:0] {
    UOP_MUL_GRAV  = 4'd0,
    UOP_MUL_DRAG  = 4'd1,
    UOP_FACTOR    = 4'd2,
    UOP_MUL_VX    = 4'd3,
    UOP_VX_MUL_VZ = 4'd4,
    UOP_VZ_MUL_PX = 4'd5,
    UOP_PX_MUL_PY = 4'd6,
    UOP_PY_MUL_PZ = 4'd7,
    UOP_PZ        = 4'd8
  } uop_e;

  typedef struct packed {
    q_t          gravity;
    logic [30:0] drag;
    q_t          max_fall;
    logic [16:0] min_dt;
    logic [16:0] max_dt;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    q_t          field_x;
    q_t          field_y;
    q_t          field_z;
    q_t          vel_in_x;
    q_t          vel_in_y;
    q_t          vel_in_z;
    q_t          center_y_offset;
    logic [4:0]  slot_flags;
    logic [30:0] time_step;
  } in_t;

  typedef struct packed {
    logic       wr_shape;
    logic       wr_motion;
    logic       latch_dt;
    logic       rd;
    idx_t       rd_idx;
    idx_t       cur;
    idx_t       oth;
    logic       load_cur;
    logic       phys;
    uop_e       uop;
    logic       mk_box;
    logic       o_box;
    logic       o_pen;
    logic       o_push;
    logic       wb;
    logic       out_load;
    logic       out_zero;
    logic       out_last;
    logic [3:0] out_slot;
  } cmd_t;

  typedef struct packed {
    logic cur_moves;
    logic cur_collide;
    logic oth_ok;
    logic out_taken;
  } status_t;

  function automatic q_t sat36(input logic signed [35:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[31:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rbs_if.sv =====
// input and result channel interfaces
`default_nettype none
interface rbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         slot;
  logic signed [31:0] field_x;
  logic signed [31:0] field_y;
  logic signed [31:0] field_z;
  logic signed [31:0] vel_in_x;
  logic signed [31:0] vel_in_y;
  logic signed [31:0] vel_in_z;
  logic signed [31:0] center_y_offset;
  logic [4:0]         slot_flags;
  logic [30:0]        time_step;

  modport source (output valid, opcode, slot, field_x, field_y, field_z, vel_in_x,
                  vel_in_y, vel_in_z, center_y_offset, slot_flags, time_step,
                  input ready);
  modport sink (input valid, opcode, slot, field_x, field_y, field_z, vel_in_x,
                vel_in_y, vel_in_z, center_y_offset, slot_flags, time_step,
                output ready);
endinterface

interface rbs_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic               grounded;
  logic               last;

  modport source (output valid, out_slot, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  grounded, last, input ready);
  modport sink (input valid, out_slot, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                grounded, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/rbs_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module rbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rbs_ctrl.sv =====
// sequencer for write, read and step items
`default_nettype none
module rbs_ctrl #(
  parameter int ENTITIES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      in_opcode_i,
  input  wire logic [3:0]      in_slot_i,
  output logic                 in_ready_o,
  input  wire rbs_pkg::status_t st_i,
  output rbs_pkg::cmd_t        cmd_o
);
  import rbs_pkg::*;

  localparam int IW = $clog2(ENTITIES);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] S_END  = CW'(ENTITIES);
  localparam logic [CW-1:0] S_LAST = CW'(ENTITIES - 1);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_S_SEL  = 13'b0000000000010,
    ST_LOAD   = 13'b0000000000100,
    ST_PHYS   = 13'b0000000001000,
    ST_BOX    = 13'b0000000010000,
    ST_O_SEL  = 13'b0000000100000,
    ST_O_BOX  = 13'b0000001000000,
    ST_O_PEN  = 13'b0000010000000,
    ST_O_PUSH = 13'b0000100000000,
    ST_WB     = 13'b0001000000000,
    ST_E_RD   = 13'b0010000000000,
    ST_E_LOAD = 13'b0100000000000,
    ST_E_WAIT = 13'b1000000000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] s_q, s_d, o_q, o_d;
  uop_e          uop_q, uop_d;
  logic          rmode_q, rmode_d;
  logic [3:0]    rslot_q, rslot_d;

  logic [8:0] in_slot9, rslot9, s9;
  logic       in_slot_ok, rslot_ok;

  assign in_slot9   = 9'(in_slot_i);
  assign rslot9     = 9'(rslot_q);
  assign s9         = 9'(s_q);
  assign in_slot_ok = in_slot9 < 9'(ENTITIES);
  assign rslot_ok   = rslot9 < 9'(ENTITIES);

  always_comb begin
    state_d    = state_q;
    s_d        = s_q;
    o_d        = o_q;
    uop_d      = uop_q;
    rmode_d    = rmode_q;
    rslot_d    = rslot_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.cur  = idx_t'(s_q[IW-1:0]);
    cmd_o.oth  = idx_t'(o_q[IW-1:0]);
    cmd_o.uop  = uop_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_e'(in_opcode_i))
            OP_SHAPE:  cmd_o.wr_shape = in_slot_ok;
            OP_MOTION: cmd_o.wr_motion = in_slot_ok;
            OP_STEP: begin
              cmd_o.latch_dt = 1'b1;
              s_d            = '0;
              rmode_d        = 1'b0;
              state_d        = ST_S_SEL;
            end
            OP_READ: begin
              cmd_o.rd     = in_slot_ok;
              cmd_o.rd_idx = idx_t'(in_slot9[IW-1:0]);
              rmode_d      = 1'b1;
              rslot_d      = in_slot_i;
              state_d      = ST_E_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_S_SEL: begin
        if (s_q == S_END) begin
          s_d     = '0;
          state_d = ST_E_RD;
        end else if (st_i.cur_moves) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_idx = cmd_o.cur;
          state_d      = ST_LOAD;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd_o.load_cur = 1'b1;
        uop_d          = UOP_MUL_GRAV;
        state_d        = ST_PHYS;
      end
      ST_PHYS: begin
        cmd_o.phys = 1'b1;
        if (uop_q == UOP_PZ) begin
          state_d = st_i.cur_collide ? ST_BOX : ST_WB;
        end else begin
          uop_d = uop_e'(uop_q + 4'd1);
        end
      end
      ST_BOX: begin
        cmd_o.mk_box = 1'b1;
        o_d          = '0;
        state_d      = ST_O_SEL;
      end
      ST_O_SEL: begin
        if (o_q == S_END) begin
          state_d = ST_WB;
        end else if (o_q == s_q || !st_i.oth_ok) begin
          o_d = o_q + 1'b1;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_idx = cmd_o.oth;
          state_d      = ST_O_BOX;
        end
      end
      ST_O_BOX: begin
        cmd_o.o_box = 1'b1;
        state_d     = ST_O_PEN;
      end
      ST_O_PEN: begin
        cmd_o.o_pen = 1'b1;
        state_d     = ST_O_PUSH;
      end
      ST_O_PUSH: begin
        cmd_o.o_push = 1'b1;
        o_d          = o_q + 1'b1;
        state_d      = ST_O_SEL;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        s_d      = s_q + 1'b1;
        state_d  = ST_S_SEL;
      end
      ST_E_RD: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_idx = cmd_o.cur;
        state_d      = ST_E_LOAD;
      end
      ST_E_LOAD: begin
        cmd_o.out_load = 1'b1;
        if (rmode_q) begin
          cmd_o.cur      = idx_t'(rslot9[IW-1:0]);
          cmd_o.out_slot = rslot_q;
          cmd_o.out_zero = !rslot_ok;
          cmd_o.out_last = 1'b1;
        end else begin
          cmd_o.out_slot = s9[3:0];
          cmd_o.out_last = (s_q == S_LAST);
        end
        state_d = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (st_i.out_taken) begin
          if (rmode_q || s_q == S_LAST) begin
            state_d = ST_IDLE;
          end else begin
            s_d     = s_q + 1'b1;
            state_d = ST_E_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s_q     <= '0;
      o_q     <= '0;
      uop_q   <= UOP_MUL_GRAV;
      rmode_q <= 1'b0;
      rslot_q <= '0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      o_q     <= o_d;
      uop_q   <= uop_d;
      rmode_q <= rmode_d;
      rslot_q <= rslot_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rbs_dp.sv =====
// entity tables, shared multiplier, box test and result register
`default_nettype none
module rbs_dp #(
  parameter int ENTITIES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rbs_pkg::cfg_t   cfg_i,
  input  wire rbs_pkg::in_t    in_i,
  input  wire rbs_pkg::cmd_t   cmd_i,
  output rbs_pkg::status_t     st_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [3:0]           out_slot_o,
  output rbs_pkg::q_t          pos_x_o,
  output rbs_pkg::q_t          pos_y_o,
  output rbs_pkg::q_t          pos_z_o,
  output rbs_pkg::q_t          vel_x_o,
  output rbs_pkg::q_t          vel_y_o,
  output rbs_pkg::q_t          vel_z_o,
  output logic                 grounded_o,
  output logic                 last_o
);
  import rbs_pkg::*;

  localparam int IW = $clog2(ENTITIES);

  logic [4:0] flags_q [ENTITIES];
  logic       gnd_q   [ENTITIES];

  logic [IW-1:0] cur, oth, slot_idx, rd_idx;
  logic [8:0]    slot9;
  assign cur      = cmd_i.cur[IW-1:0];
  assign oth      = cmd_i.oth[IW-1:0];
  assign rd_idx   = cmd_i.rd_idx[IW-1:0];
  assign slot9    = 9'(in_i.slot);
  assign slot_idx = slot9[IW-1:0];

  // working copy of the slot under step
  q_t                 p_q [3];
  q_t                 v_q [3];
  q_t                 h_q [3];
  q_t                 off_q;
  logic               wgnd_q;
  logic [16:0]        dt_q;
  logic [16:0]        fac_q;
  logic signed [34:0] prod_q;
  logic signed [33:0] lo_q [3];
  logic signed [33:0] hi_q [3];
  logic signed [32:0] cy_q;
  logic signed [33:0] olo_q [3];
  logic signed [33:0] ohi_q [3];
  logic signed [32:0] ocy_q;
  q_t                 opx_q, opz_q;
  logic signed [34:0] pen_q [3];
  logic               hit_q;

  // memories
  logic [191:0] mrd, mwd;
  logic [127:0] srd;
  logic         mwe;
  logic [IW-1:0] mwa;

  assign mwe = cmd_i.wr_motion | cmd_i.wb;
  assign mwa = cmd_i.wr_motion ? slot_idx : cur;
  assign mwd = cmd_i.wr_motion ?
               {in_i.vel_in_z, in_i.vel_in_y, in_i.vel_in_x,
                in_i.field_z, in_i.field_y, in_i.field_x} :
               {v_q[2], v_q[1], v_q[0], p_q[2], p_q[1], p_q[0]};

  rbs_ram #(.WIDTH(192), .DEPTH(ENTITIES)) u_motion_ram (
    .clk_i   (clk_i),
    .we_i    (mwe),
    .waddr_i (mwa),
    .wdata_i (mwd),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_idx),
    .rdata_o (mrd)
  );

  rbs_ram #(.WIDTH(128), .DEPTH(ENTITIES)) u_shape_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_shape),
    .waddr_i (slot_idx),
    .wdata_i ({in_i.center_y_offset, in_i.field_z, in_i.field_y, in_i.field_x}),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_idx),
    .rdata_o (srd)
  );

  q_t rp [3];
  q_t rv [3];
  q_t rh [3];
  q_t roff;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rp[a] = $signed(mrd[32*a +: 32]);
      rv[a] = $signed(mrd[96 + 32*a +: 32]);
      rh[a] = $signed(srd[32*a +: 32]);
    end
    roff = $signed(srd[127:96]);
  end

  // status
  logic [4:0] cf, of;
  assign cf = flags_q[cur];
  assign of = flags_q[oth];
  assign st_o.cur_moves   = cf[F_VALID] & cf[F_MOVES];
  assign st_o.cur_collide = cf[F_CHECK] & cf[F_COLL];
  assign st_o.oth_ok      = of[F_VALID] & of[F_COLL];
  assign st_o.out_taken   = out_valid_o & out_ready_i;

  // shared multiplier with round-half-up and floor shift
  logic signed [32:0] ma;
  logic signed [17:0] mb;
  logic signed [50:0] mprod;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.uop)
      UOP_MUL_GRAV: begin
        ma = 33'(cfg_i.gravity);
        mb = $signed({1'b0, dt_q});
      end
      UOP_MUL_DRAG: begin
        ma = $signed({2'b00, cfg_i.drag});
        mb = $signed({1'b0, dt_q});
      end
      UOP_MUL_VX: begin
        ma = 33'(v_q[0]);
        mb = $signed({1'b0, fac_q});
      end
      UOP_VX_MUL_VZ: begin
        ma = 33'(v_q[2]);
        mb = $signed({1'b0, fac_q});
      end
      UOP_VZ_MUL_PX: begin
        ma = 33'(v_q[0]);
        mb = $signed({1'b0, dt_q});
      end
      UOP_PX_MUL_PY: begin
        ma = 33'(v_q[1]);
        mb = $signed({1'b0, dt_q});
      end
      UOP_PY_MUL_PZ: begin
        ma = 33'(v_q[2]);
        mb = $signed({1'b0, dt_q});
      end
      default: ;
    endcase
    mprod = 51'(ma) * 51'(mb) + 51'sd32768;
  end

  // box centers: own from the integrated position, other from the read entry
  logic signed [33:0] c_w [3];
  logic signed [33:0] oc_w [3];
  always_comb begin
    c_w[0]  = 34'(p_q[0]);
    c_w[1]  = 34'(p_q[1]) + 34'(off_q);
    c_w[2]  = 34'(p_q[2]);
    oc_w[0] = 34'(rp[0]);
    oc_w[1] = 34'(rp[1]) + 34'(roff);
    oc_w[2] = 34'(rp[2]);
  end

  logic signed [34:0] pen_w [3];
  logic               hit_w;
  always_comb begin
    logic signed [34:0] d1, d2;
    hit_w = 1'b1;
    for (int a = 0; a < 3; a++) begin
      d1 = 35'(hi_q[a]) - 35'(olo_q[a]);
      d2 = 35'(ohi_q[a]) - 35'(lo_q[a]);
      pen_w[a] = (d1 < d2) ? d1 : d2;
      if (!(lo_q[a] <= ohi_q[a] && hi_q[a] >= olo_q[a])) begin
        hit_w = 1'b0;
      end
    end
  end

  logic ax_x, ax_y;
  q_t   px_neg, px_pos, py_neg, py_pos, pz_neg, pz_pos;
  assign ax_x   = (pen_q[0] < pen_q[1]) && (pen_q[0] < pen_q[2]);
  assign ax_y   = !ax_x && (pen_q[1] < pen_q[2]);
  assign px_neg = sat36(36'(p_q[0]) - 36'(pen_q[0]));
  assign px_pos = sat36(36'(p_q[0]) + 36'(pen_q[0]));
  assign py_neg = sat36(36'(p_q[1]) - 36'(pen_q[1]));
  assign py_pos = sat36(36'(p_q[1]) + 36'(pen_q[1]));
  assign pz_neg = sat36(36'(p_q[2]) - 36'(pen_q[2]));
  assign pz_pos = sat36(36'(p_q[2]) + 36'(pen_q[2]));

  // time step clamp
  logic [30:0] dt_lo;
  logic [30:0] dt_c;
  assign dt_lo = (in_i.time_step < 31'(cfg_i.min_dt)) ? 31'(cfg_i.min_dt) : in_i.time_step;
  assign dt_c  = (dt_lo > 31'(cfg_i.max_dt)) ? 31'(cfg_i.max_dt) : dt_lo;

  q_t vy_clamped;
  assign vy_clamped = (v_q[1] < cfg_i.max_fall) ? cfg_i.max_fall : v_q[1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_dt) begin
      dt_q <= dt_c[16:0];
    end
    if (cmd_i.load_cur) begin
      for (int a = 0; a < 3; a++) begin
        p_q[a] <= rp[a];
        v_q[a] <= rv[a];
        h_q[a] <= rh[a];
      end
      off_q  <= roff;
      wgnd_q <= gnd_q[cur];
    end
    if (cmd_i.phys) begin
      prod_q <= mprod[50:16];
      unique case (cmd_i.uop)
        UOP_MUL_DRAG: begin
          if (cf[F_GRAV]) begin
            v_q[1] <= sat36(36'(v_q[1]) + 36'(prod_q));
          end
        end
        UOP_FACTOR: begin
          fac_q  <= (prod_q > 35'(ONE_Q)) ? 17'd0 : 17'(35'(ONE_Q) - prod_q);
          v_q[1] <= vy_clamped;
        end
        UOP_VX_MUL_VZ: v_q[0] <= sat36(36'(prod_q));
        UOP_VZ_MUL_PX: v_q[2] <= sat36(36'(prod_q));
        UOP_PX_MUL_PY: p_q[0] <= sat36(36'(p_q[0]) + 36'(prod_q));
        UOP_PY_MUL_PZ: p_q[1] <= sat36(36'(p_q[1]) + 36'(prod_q));
        UOP_PZ:        p_q[2] <= sat36(36'(p_q[2]) + 36'(prod_q));
        default: ;
      endcase
    end
    if (cmd_i.mk_box) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= c_w[a] - 34'(h_q[a]);
        hi_q[a] <= c_w[a] + 34'(h_q[a]);
      end
      cy_q   <= c_w[1][32:0];
      wgnd_q <= 1'b0;
    end
    if (cmd_i.o_box) begin
      for (int a = 0; a < 3; a++) begin
        olo_q[a] <= oc_w[a] - 34'(rh[a]);
        ohi_q[a] <= oc_w[a] + 34'(rh[a]);
      end
      ocy_q <= oc_w[1][32:0];
      opx_q <= rp[0];
      opz_q <= rp[2];
    end
    if (cmd_i.o_pen) begin
      for (int a = 0; a < 3; a++) begin
        pen_q[a] <= pen_w[a];
      end
      hit_q <= hit_w;
    end
    if (cmd_i.o_push && hit_q) begin
      priority if (ax_x) begin
        p_q[0] <= (p_q[0] < opx_q) ? px_neg : px_pos;
        v_q[0] <= '0;
      end else if (ax_y) begin
        if (cy_q < ocy_q) begin
          p_q[1] <= py_neg;
        end else begin
          p_q[1] <= py_pos;
          wgnd_q <= 1'b1;
        end
        v_q[1] <= '0;
      end else begin
        p_q[2] <= (p_q[2] < opz_q) ? pz_neg : pz_pos;
        v_q[2] <= '0;
      end
    end
  end

  // flags and grounded bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < ENTITIES; e++) begin
        flags_q[e] <= '0;
        gnd_q[e]   <= 1'b0;
      end
    end else begin
      if (cmd_i.wr_shape) begin
        flags_q[slot_idx] <= in_i.slot_flags;
      end
      if (cmd_i.wb) begin
        gnd_q[cur] <= wgnd_q;
      end
    end
  end

  // result register
  logic out_zero;
  assign out_zero = cmd_i.out_zero | !cf[F_VALID];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_slot_o <= cmd_i.out_slot;
      last_o     <= cmd_i.out_last;
      pos_x_o    <= out_zero ? '0 : rp[0];
      pos_y_o    <= out_zero ? '0 : rp[1];
      pos_z_o    <= out_zero ? '0 : rp[2];
      vel_x_o    <= out_zero ? '0 : rv[0];
      vel_y_o    <= out_zero ? '0 : rv[1];
      vel_z_o    <= out_zero ? '0 : rv[2];
      grounded_o <= out_zero ? 1'b0 : gnd_q[cur];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rigid_body_step_aabb_resolve.sv =====
// top level of the rigid body stepper with box push-out
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------------
//  in_i    | in  | valid/ready        | opcode, slot, shape or motion, time step
//  out_o   | out | valid/ready        | slot state after step or read, last flag
//  apb     | in  | psel/penable/pready| five global registers at byte addr 4*i
//
// read item: entity ram read into the result register, then held until the
// transfer. step item: a slot that does not move is passed over; a moving slot is
// read, loaded and run through the physics micro-steps (one shared multiplier, one
// micro-step a cycle); if it collides, its box is built and each other colliding
// slot read, boxed, measured and pushed against (single read port of the entity
// ram), then written back. the results follow in turn, held through output stalls.
// reset is asynchronous and active low; flags and grounded bits clear at once,
// the entity ram holds no reset. a stalled result blocks all further work.
`default_nettype none
module rigid_body_step_aabb_resolve #(
  parameter int ENTITIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rbs_in_if.sink           in_i,
  rbs_out_if.source        out_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);
  import rbs_pkg::*;

  cfg_t    cfg_q;
  in_t     in_pl;
  cmd_t    cmd;
  status_t st;
  logic    cfg_we;
  reg_e    cfg_sel;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;
  assign cfg_sel  = reg_e'(paddr_i[4:2]);

  // global registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity  <= -32'sd642908;
      cfg_q.drag     <= '0;
      cfg_q.max_fall <= -32'sd3276800;
      cfg_q.min_dt   <= 17'd66;
      cfg_q.max_dt   <= 17'd6554;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_GRAVITY:  cfg_q.gravity  <= pwdata_i;
        REG_DRAG:     cfg_q.drag     <= pwdata_i[30:0];
        REG_MAX_FALL: cfg_q.max_fall <= pwdata_i;
        REG_MIN_DT:   cfg_q.min_dt   <= pwdata_i[16:0];
        REG_MAX_DT:   cfg_q.max_dt   <= pwdata_i[16:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_sel)
      REG_GRAVITY:  prdata_o = cfg_q.gravity;
      REG_DRAG:     prdata_o = {1'b0, cfg_q.drag};
      REG_MAX_FALL: prdata_o = cfg_q.max_fall;
      REG_MIN_DT:   prdata_o = 32'(cfg_q.min_dt);
      REG_MAX_DT:   prdata_o = 32'(cfg_q.max_dt);
      default:      prdata_o = '0;
    endcase
  end

  // input payload as one bundle for the datapath
  assign in_pl.opcode          = in_i.opcode;
  assign in_pl.slot            = in_i.slot;
  assign in_pl.field_x         = in_i.field_x;
  assign in_pl.field_y         = in_i.field_y;
  assign in_pl.field_z         = in_i.field_z;
  assign in_pl.vel_in_x        = in_i.vel_in_x;
  assign in_pl.vel_in_y        = in_i.vel_in_y;
  assign in_pl.vel_in_z        = in_i.vel_in_z;
  assign in_pl.center_y_offset = in_i.center_y_offset;
  assign in_pl.slot_flags      = in_i.slot_flags;
  assign in_pl.time_step       = in_i.time_step;

  rbs_ctrl #(.ENTITIES(ENTITIES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_slot_i   (in_i.slot),
    .in_ready_o  (in_i.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  rbs_dp #(.ENTITIES(ENTITIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_pl),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_slot_o  (out_o.out_slot),
    .pos_x_o     (out_o.pos_x),
    .pos_y_o     (out_o.pos_y),
    .pos_z_o     (out_o.pos_z),
    .vel_x_o     (out_o.vel_x),
    .vel_y_o     (out_o.vel_y),
    .vel_z_o     (out_o.vel_z),
    .grounded_o  (out_o.grounded),
    .last_o      (out_o.last)
  );
endmodule
`default_nettype wire

// ===== rtl/rbs_checker.sv =====
// port-level checks of the stepper, bound to the top level
`default_nettype none
`include "rigid_body_step_aabb_resolve_defines.svh"
module rbs_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_last_i,
  input wire logic [31:0] out_pos_x_i
);
  // no new item while a result waits
  `RBS_ASSERT_SAME(a_busy_while_result, clk_i, rst_ni, out_valid_i, !in_ready_i)
  // more results of the same item follow before a new item is taken
  `RBS_ASSERT_NEXT(a_not_last_blocks, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, !in_ready_i)
  // a stalled result stays up with its data
  `RBS_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_pos_x_i))
  // nothing offered in reset
  `RBS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni, !out_valid_i)
endmodule

bind rigid_body_step_aabb_resolve rbs_assert u_rbs_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last),
  .out_pos_x_i (out_o.pos_x)
);
`default_nettype wire

// ===== tb/rbs_checker.sv =====
// result checker and state predictor for the rigid body stepper
`timescale 1ns / 100ps
module rbs_checker
  import rbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rbs_in_if           in_mon,
  rbs_out_if          out_mon,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int SLOTS = 16;

  typedef struct {
    logic [3:0]  slot;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic        grounded;
    logic        last;
  } slot_report_t;

  slot_report_t report_q[$];

  longint pos_m [SLOTS][3];
  longint vel_m [SLOTS][3];
  longint ext_m [SLOTS][3];
  longint cofs_m [SLOTS];
  logic [4:0] flags_m [SLOTS];
  logic grnd_m [SLOTS];

  longint gravity_r, drag_r, max_fall_r, min_dt_r, max_dt_r;

  assign pending_o = report_q.size();

  function automatic longint q_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint pen_min(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic void push_out(int s);
    longint lo[3], hi[3], c[3], oc[3], olo[3], ohi[3], pen[3];
    bit hit;
    int ax;
    grnd_m[s] = 1'b0;
    c[0] = pos_m[s][0];
    c[1] = pos_m[s][1] + cofs_m[s];
    c[2] = pos_m[s][2];
    for (int a = 0; a < 3; a++) begin
      lo[a] = c[a] - ext_m[s][a];
      hi[a] = c[a] + ext_m[s][a];
    end
    for (int o = 0; o < SLOTS; o++) begin
      if (o == s || !flags_m[o][F_VALID] || !flags_m[o][F_COLL]) continue;
      hit = 1'b1;
      oc[0] = pos_m[o][0];
      oc[1] = pos_m[o][1] + cofs_m[o];
      oc[2] = pos_m[o][2];
      for (int a = 0; a < 3; a++) begin
        olo[a] = oc[a] - ext_m[o][a];
        ohi[a] = oc[a] + ext_m[o][a];
        if (!(lo[a] <= ohi[a] && hi[a] >= olo[a])) hit = 1'b0;
        pen[a] = pen_min(hi[a] - olo[a], ohi[a] - lo[a]);
      end
      if (!hit) continue;
      if (pen[0] < pen[1] && pen[0] < pen[2]) ax = 0;
      else if (pen[1] < pen[2]) ax = 1;
      else ax = 2;
      if (ax == 1) begin
        // vertical: compare box centers, push up means resting
        if (c[1] < oc[1]) begin
          pos_m[s][1] = clip32(pos_m[s][1] - pen[1]);
        end else begin
          pos_m[s][1] = clip32(pos_m[s][1] + pen[1]);
          grnd_m[s] = 1'b1;
        end
      end else if (pos_m[s][ax] < pos_m[o][ax]) begin
        pos_m[s][ax] = clip32(pos_m[s][ax] - pen[ax]);
      end else begin
        pos_m[s][ax] = clip32(pos_m[s][ax] + pen[ax]);
      end
      vel_m[s][ax] = 0;
    end
  endfunction

  function automatic void integrate(int s, longint dt);
    longint fac;
    if (!flags_m[s][F_VALID] || !flags_m[s][F_MOVES]) return;
    if (flags_m[s][F_GRAV]) vel_m[s][1] = clip32(vel_m[s][1] + q_mul(gravity_r, dt));
    fac = 65536 - q_mul(drag_r, dt);
    if (fac < 0) fac = 0;
    vel_m[s][0] = clip32(q_mul(vel_m[s][0], fac));
    vel_m[s][2] = clip32(q_mul(vel_m[s][2], fac));
    if (vel_m[s][1] < max_fall_r) vel_m[s][1] = max_fall_r;
    for (int a = 0; a < 3; a++) pos_m[s][a] = clip32(pos_m[s][a] + q_mul(vel_m[s][a], dt));
    if (flags_m[s][F_CHECK] && flags_m[s][F_COLL]) push_out(s);
  endfunction

  function automatic void queue_report(int s, bit last);
    slot_report_t r;
    r = '{slot: s[3:0], default: '0};
    if (flags_m[s][F_VALID]) begin
      r.px = pos_m[s][0][31:0];
      r.py = pos_m[s][1][31:0];
      r.pz = pos_m[s][2][31:0];
      r.vx = vel_m[s][0][31:0];
      r.vy = vel_m[s][1][31:0];
      r.vz = vel_m[s][2][31:0];
      r.grounded = grnd_m[s];
    end
    r.last = last;
    report_q.push_back(r);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    longint dt;
    slot_report_t r;
    if (!rst_ni) begin
      report_q.delete();
      fail_count_o = 0;
      for (int s = 0; s < SLOTS; s++) begin
        flags_m[s] = '0;
        grnd_m[s] = 1'b0;
      end
      gravity_r = -642908;
      drag_r = 0;
      max_fall_r = -3276800;
      min_dt_r = 66;
      max_dt_r = 6554;
    end else begin
      // register write lands on the access cycle
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[4:2]))
          REG_GRAVITY:  gravity_r = longint'($signed(pwdata_i));
          REG_DRAG:     drag_r = longint'(pwdata_i[30:0]);
          REG_MAX_FALL: max_fall_r = longint'($signed(pwdata_i));
          REG_MIN_DT:   min_dt_r = longint'(pwdata_i[16:0]);
          REG_MAX_DT:   max_dt_r = longint'(pwdata_i[16:0]);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          $error("result transfer with nothing expected, slot %0d", out_mon.out_slot);
          fail_count_o++;
        end else begin
          r = report_q.pop_front();
          check_field("out_slot", r.slot, out_mon.out_slot);
          check_field("pos_x", r.px, out_mon.pos_x);
          check_field("pos_y", r.py, out_mon.pos_y);
          check_field("pos_z", r.pz, out_mon.pos_z);
          check_field("vel_x", r.vx, out_mon.vel_x);
          check_field("vel_y", r.vy, out_mon.vel_y);
          check_field("vel_z", r.vz, out_mon.vel_z);
          check_field("grounded", r.grounded, out_mon.grounded);
          check_field("last", r.last, out_mon.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (op_e'(in_mon.opcode))
          OP_SHAPE: begin
            ext_m[in_mon.slot][0] = longint'(in_mon.field_x);
            ext_m[in_mon.slot][1] = longint'(in_mon.field_y);
            ext_m[in_mon.slot][2] = longint'(in_mon.field_z);
            cofs_m[in_mon.slot] = longint'(in_mon.center_y_offset);
            flags_m[in_mon.slot] = in_mon.slot_flags;
          end
          OP_MOTION: begin
            pos_m[in_mon.slot][0] = longint'(in_mon.field_x);
            pos_m[in_mon.slot][1] = longint'(in_mon.field_y);
            pos_m[in_mon.slot][2] = longint'(in_mon.field_z);
            vel_m[in_mon.slot][0] = longint'(in_mon.vel_in_x);
            vel_m[in_mon.slot][1] = longint'(in_mon.vel_in_y);
            vel_m[in_mon.slot][2] = longint'(in_mon.vel_in_z);
          end
          OP_STEP: begin
            dt = longint'(in_mon.time_step);
            if (dt < min_dt_r) dt = min_dt_r;
            if (dt > max_dt_r) dt = max_dt_r;
            for (int s = 0; s < SLOTS; s++) integrate(s, dt);
            for (int s = 0; s < SLOTS; s++) queue_report(s, s == SLOTS - 1);
          end
          default: queue_report(in_mon.slot, 1'b1);
        endcase
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// stimulus, clock, reset and verdict for the rigid body stepper
`timescale 1ns / 100ps
module testbench;
  import rbs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          send_idle;
  int          recv_idle;
  // a slot may only be marked valid once its motion has been loaded
  bit          motion_loaded [16];

  rbs_in_if  in_if ();
  rbs_out_if out_if ();

  rigid_body_step_aabb_resolve dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .out_o     (out_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  rbs_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("testbench failed");
    $finish;
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_idle);
  end

  // two-phase register write, pready is tied high by the block
  task automatic cfg_write(reg_e r, logic [31:0] v);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] g, logic [31:0] d, logic [31:0] mf,
                         logic [31:0] lo, logic [31:0] hi);
    cfg_write(REG_GRAVITY, g);
    cfg_write(REG_DRAG, d);
    cfg_write(REG_MAX_FALL, mf);
    cfg_write(REG_MIN_DT, lo);
    cfg_write(REG_MAX_DT, hi);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    if (it.opcode == OP_SHAPE && !motion_loaded[it.slot]) it.slot_flags[F_VALID] = 1'b0;
    if (it.opcode == OP_MOTION) motion_loaded[it.slot] = 1'b1;
    in_if.opcode = it.opcode;
    in_if.slot = it.slot;
    in_if.field_x = it.field_x;
    in_if.field_y = it.field_y;
    in_if.field_z = it.field_z;
    in_if.vel_in_x = it.vel_in_x;
    in_if.vel_in_y = it.vel_in_y;
    in_if.vel_in_z = it.vel_in_z;
    in_if.center_y_offset = it.center_y_offset;
    in_if.slot_flags = it.slot_flags;
    in_if.time_step = it.time_step;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic in_t noise_item();
    in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          10'($urandom)};
    return it;
  endfunction

  function automatic logic [31:0] near(int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // mostly clustered boxes so that contacts and pushes happen often
  function automatic in_t random_item();
    in_t it;
    int pick;
    it = noise_item();
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.opcode = OP_MOTION;
      if ($urandom_range(9) != 0) begin
        it.field_x = near(3 * 65536);
        it.field_y = near(3 * 65536);
        it.field_z = near(3 * 65536);
        it.vel_in_x = near(4 * 65536);
        it.vel_in_y = near(4 * 65536);
        it.vel_in_z = near(4 * 65536);
      end
    end else if (pick < 50) begin
      it.opcode = OP_SHAPE;
      if ($urandom_range(9) != 0) begin
        it.field_x = 32'($urandom_range(98304, 16384));
        it.field_y = 32'($urandom_range(98304, 16384));
        it.field_z = 32'($urandom_range(98304, 16384));
        it.center_y_offset = near(32768);
        it.slot_flags = 5'($urandom_range(31)) | 5'b00001;
      end
    end else if (pick < 80) begin
      it.opcode = OP_STEP;
      if ($urandom_range(4) != 0) it.time_step = 31'($urandom_range(9000));
    end else begin
      it.opcode = OP_READ;
    end
    return it;
  endfunction

  initial begin
    in_t it;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_READ;
    in_if.slot = '0;
    in_if.field_x = '0;
    in_if.field_y = '0;
    in_if.field_z = '0;
    in_if.vel_in_x = '0;
    in_if.vel_in_y = '0;
    in_if.vel_in_z = '0;
    in_if.center_y_offset = '0;
    in_if.slot_flags = '0;
    in_if.time_step = '0;
    out_if.ready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reads of empty slots, extreme values, stacked boxes, clamps
    it = noise_item(); it.opcode = OP_READ; it.slot = 4'd15; send_item(it);
    it = noise_item(); it.opcode = OP_STEP; it.time_step = '0; send_item(it);
    it = noise_item(); it.opcode = OP_MOTION; it.slot = 4'd0;
    it.field_x = 32'h7fffffff; it.field_y = 32'h7fffffff; it.field_z = 32'h80000000;
    it.vel_in_x = 32'h7fffffff; it.vel_in_y = 32'h80000000; it.vel_in_z = 32'h80000000;
    send_item(it);
    it = noise_item(); it.opcode = OP_SHAPE; it.slot = 4'd0; it.slot_flags = 5'h1f;
    it.field_x = 32'h80000000; it.field_y = 32'h7fffffff; it.field_z = 32'hffff0000;
    it.center_y_offset = 32'h7fffffff; send_item(it);
    // a box resting on a floor slab and one beside it
    it = noise_item(); it.opcode = OP_MOTION; it.slot = 4'd1;
    it.field_x = '0; it.field_y = '0; it.field_z = '0;
    it.vel_in_x = '0; it.vel_in_y = '0; it.vel_in_z = '0; send_item(it);
    it = noise_item(); it.opcode = OP_SHAPE; it.slot = 4'd1; it.slot_flags = 5'h11;
    it.field_x = 32'd655360; it.field_y = 32'd65536; it.field_z = 32'd655360;
    it.center_y_offset = '0; send_item(it);
    it = noise_item(); it.opcode = OP_MOTION; it.slot = 4'd2;
    it.field_x = 32'd32768; it.field_y = 32'd120000; it.field_z = '0;
    it.vel_in_x = 32'd65536; it.vel_in_y = '0; it.vel_in_z = 32'hffff0000; send_item(it);
    it = noise_item(); it.opcode = OP_SHAPE; it.slot = 4'd2; it.slot_flags = 5'h1f;
    it.field_x = 32'd32768; it.field_y = 32'd32768; it.field_z = 32'd32768;
    it.center_y_offset = '0; send_item(it);
    it = noise_item(); it.opcode = OP_MOTION; it.slot = 4'd3;
    it.field_x = 32'd700000; it.field_y = 32'd100000; it.field_z = 32'd10000;
    it.vel_in_x = 32'hfffe0000; it.vel_in_y = 32'd20000; it.vel_in_z = '0; send_item(it);
    it = noise_item(); it.opcode = OP_SHAPE; it.slot = 4'd3; it.slot_flags = 5'h1b;
    it.field_x = 32'd40000; it.field_y = 32'd40000; it.field_z = 32'd40000;
    it.center_y_offset = 32'hffff8000; send_item(it);
    it = noise_item(); it.opcode = OP_STEP; it.time_step = 31'h7fffffff; send_item(it);
    it = noise_item(); it.opcode = OP_STEP; it.time_step = 31'd1000; send_item(it);
    it = noise_item(); it.opcode = OP_READ; it.slot = 4'd2; send_item(it);
    it = noise_item(); it.opcode = OP_READ; it.slot = 4'd9; send_item(it);
    // a write to a shape leaves the grounded bit alone
    it = noise_item(); it.opcode = OP_SHAPE; it.slot = 4'd2; it.slot_flags = 5'h1f;
    it.field_x = 32'd32768; it.field_y = 32'd32768; it.field_z = 32'd32768;
    it.center_y_offset = '0; send_item(it);
    it = noise_item(); it.opcode = OP_READ; it.slot = 4'd2; send_item(it);
    drain();

    // settings: reset-like with drag, both high extremes, low extremes with
    // the lower clamp above the upper one, then a gentle setup
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle = 27; recv_idle = 83;
          cfg_all(32'hfff630a4, 32'd32768, 32'hffce0000, 32'd66, 32'd6554);
        end
        1: begin
          send_idle = 83; recv_idle = 27;
          cfg_all(32'h7fffffff, 32'h7fffffff, 32'h0, 32'd65536, 32'd65536);
        end
        2: begin
          send_idle = 0; recv_idle = 0;
          cfg_all(32'h80000000, 32'h0, 32'h80000000, 32'd500, 32'd0);
        end
        default: begin
          send_idle = 0; recv_idle = 0;
          cfg_all(32'hfff60000, 32'd200000, 32'hfff00000, 32'd0, 32'd8000);
        end
      endcase
      for (int n = 0; n < 50; n++) begin
        send_item(random_item());
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_if.sv
rtl/rbs_ram.sv
rtl/rbs_ctrl.sv
rtl/rbs_dp.sv
rtl/rigid_body_step_aabb_resolve.sv
rtl/rbs_checker.sv
tb/rbs_checker.sv
tb/testbench.sv
